// ===== rtl/lcgbps_pkg.sv =====
// Shared types and constants for the LCG Bernoulli point sampler.
// No dependencies; imported by every module of the block.
`default_nettype none

package lcgbps_pkg;

    localparam int PROB_W  = 32;   // keep probability, unsigned Q1.31
    localparam int SEED_W  = 31;   // generator word
    localparam int SIZE_W  = 21;   // cloud size, counts and slots
    localparam int TDATA_W = 24;   // SIZE_W rounded up to whole bytes
    localparam int ADDR_W  = 3;    // two 32-bit registers at byte 0 and 4
    localparam int APB_W   = 32;

    localparam logic [SEED_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
    localparam logic [15:0]       LCG_MUL  = 16'd48271;
    localparam logic [PROB_W-1:0] PROB_ONE = 32'h8000_0000;

    // Register index, taken from paddr[2]
    localparam logic REG_KEEP_PROB = 1'b0;
    localparam logic REG_RNG_SEED  = 1'b1;

    // Values the datapath uses, derived once when a register is written
    typedef struct packed {
        logic [PROB_W-1:0] prob_sat;   // probability clipped to 1.0
        logic [PROB_W-1:0] keep_thr;   // keep when r < keep_thr
        logic [SEED_W-1:0] seed_load;  // seed reduced mod 2^31-1, zero -> one
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/lcgbps_lcg.sv =====
// One step of the minimal-standard generator: x * 48271 mod (2^31 - 1).
// Depends on lcgbps_pkg. Pure combinational logic.
`default_nettype none

module lcgbps_lcg
    import lcgbps_pkg::*;
(
    input  wire logic [SEED_W-1:0] x,
    output logic      [SEED_W-1:0] r
);

    logic [SEED_W+15:0] prod;
    logic [SEED_W:0]    fold;

    // 2^31 == 1 mod M: fold the high part onto the low part; one subtract
    // finishes since the sum stays below 2M.
    always_comb begin
        prod = x * LCG_MUL;
        fold = {1'b0, prod[SEED_W-1:0]} + {{(SEED_W-15){1'b0}}, prod[SEED_W+15:SEED_W]};
        if (fold >= {1'b0, LCG_MOD}) begin
            r = SEED_W'(fold - {1'b0, LCG_MOD});
        end else begin
            r = fold[SEED_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lcgbps_regs.sv =====
// APB-style register file of the sampler: keep probability and seed.
// Depends on lcgbps_pkg; hands derived values to the datapath as cfg_t.
`default_nettype none

module lcgbps_regs
    import lcgbps_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [APB_W-1:0]  pwdata,
    output logic      [APB_W-1:0]  prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [PROB_W-1:0] prob_reg;
    logic [SEED_W-1:0] seed_reg;
    cfg_t              cfg_reg;

    logic              wr_en;
    logic [PROB_W-1:0] prob_sat_next;
    logic [PROB_W+1:0] prob_x3;
    logic [SEED_W-1:0] seed_next;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        prob_sat_next = (pwdata > PROB_ONE) ? PROB_ONE : pwdata;
        // r*2^31 < p*(2^31-3)  <=>  r < p - floor(3p / 2^31)
        prob_x3       = {prob_sat_next, 1'b0} + {2'b00, prob_sat_next};
        seed_next     = pwdata[SEED_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prob_reg           <= 32'h4000_0000;
            seed_reg           <= 31'd1;
            cfg_reg.prob_sat   <= 32'h4000_0000;
            cfg_reg.keep_thr   <= 32'h3FFF_FFFF;
            cfg_reg.seed_load  <= 31'd1;
        end else if (wr_en) begin
            case (paddr[2])
                REG_KEEP_PROB: begin
                    prob_reg         <= pwdata;
                    cfg_reg.prob_sat <= prob_sat_next;
                    cfg_reg.keep_thr <= prob_sat_next
                                        - {{(PROB_W-3){1'b0}}, prob_x3[PROB_W+1:PROB_W-1]};
                end
                REG_RNG_SEED: begin
                    seed_reg          <= seed_next;
                    cfg_reg.seed_load <= (seed_next == '0 || seed_next == LCG_MOD)
                                         ? 31'd1 : seed_next;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_KEEP_PROB: prdata = prob_reg;
            REG_RNG_SEED:  prdata = {1'b0, seed_reg};
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/lcg_bernoulli_point_sampler.sv =====
// Top level of the LCG Bernoulli point sampler.
// Depends on lcgbps_pkg, lcgbps_regs and lcgbps_lcg.
`default_nettype none

// Random point sampler. Each input transaction is one point of a cloud; the
// first point of a cloud (s_tuser set) reloads the minimal-standard generator
// from the seed register, clears the kept count and sets the cap
// floor(cloud_size * p). Every point advances the generator to r and is kept
// when r/2147483645 < p (exact integer compare) while the kept count is at
// most the cap, so up to cap+1 points survive. Each point yields exactly one
// output transaction: m_tuser is the keep flag, m_tdata the destination slot
// (for a dropped point, the current kept count). Throughput is one point per
// clock while m_tready stays high. A point passes one input register, then
// the generator multiply with its Mersenne fold, the threshold compare and the
// cap multiply, into the output register; a full output stage that m_tready
// does not drain holds it in the input register. The generator state closes
// its loop in that single stage, which is what sets the clock. Registers (APB,
// 32-bit): 0x0 keep_probability (Q1.31, values above 1.0 clip), 0x4 rng_seed.
// Write registers only while the block is idle. There is no clearing pass
// after reset.
module lcg_bernoulli_point_sampler
    import lcgbps_pkg::*;
#(
    parameter int MAX_POINTS = 1048576   // cloud_size saturates here
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // point input
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // [20:0] cloud_size, rest zero
    input  wire logic [0:0]         s_tuser,   // [0] first_of_cloud
    // decision output
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [TDATA_W-1:0] m_tdata,   // [20:0] slot, rest zero
    output logic      [0:0]         m_tuser,   // [0] keep
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [APB_W-1:0]   pwdata,
    output logic      [APB_W-1:0]   prdata,
    output logic                    pready
);

    localparam logic [24:0] MAX_SIZE = 25'(MAX_POINTS);

    cfg_t cfg;

    // input stage
    logic              in_valid_reg;
    logic              in_first_reg;
    logic [SIZE_W-1:0] in_size_reg;

    // output stage
    logic              out_valid_reg;
    logic              out_keep_reg;
    logic [SIZE_W-1:0] out_slot_reg;

    // per-cloud state
    logic [SEED_W-1:0] lcg_reg;
    logic [SIZE_W-1:0] kept_reg;
    logic [SIZE_W-1:0] cap_reg;

    logic                   advance;
    logic [SIZE_W-1:0]      size_sat;
    logic [SIZE_W+PROB_W-1:0] cap_prod;
    logic [SEED_W-1:0]      lcg_cur;
    logic [SEED_W-1:0]      lcg_next;
    logic [SIZE_W-1:0]      kept_cur;
    logic [SIZE_W-1:0]      cap_cur;
    logic                   keep_next;
    logic [SIZE_W-1:0]      kept_next;

    lcgbps_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Move the held point into the output stage when that stage is free or
    // draining this cycle.
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_keep_reg;
    assign m_tdata  = {{(TDATA_W-SIZE_W){1'b0}}, out_slot_reg};

    // first point of a cloud restarts generator, count and cap
    always_comb begin
        size_sat = ({4'b0000, in_size_reg} > MAX_SIZE) ? MAX_SIZE[SIZE_W-1:0] : in_size_reg;
        cap_prod = size_sat * cfg.prob_sat;
        lcg_cur  = in_first_reg ? cfg.seed_load : lcg_reg;
        kept_cur = in_first_reg ? '0 : kept_reg;
        cap_cur  = in_first_reg ? cap_prod[SIZE_W+PROB_W-2:PROB_W-1] : cap_reg;
    end

    lcgbps_lcg u_lcg (
        .x (lcg_cur),
        .r (lcg_next)
    );

    always_comb begin
        keep_next = ({1'b0, lcg_next} < cfg.keep_thr) && (kept_cur <= cap_cur);
        kept_next = kept_cur + SIZE_W'(keep_next);
    end

    // control and per-cloud state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lcg_reg       <= 31'd1;
            kept_reg      <= '0;
            cap_reg       <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
                lcg_reg       <= lcg_next;
                kept_reg      <= kept_next;
                cap_reg       <= cap_cur;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_first_reg <= s_tuser[0];
            in_size_reg  <= s_tdata[SIZE_W-1:0];
        end
        if (advance) begin
            out_keep_reg <= keep_next;
            out_slot_reg <= kept_cur;
        end
    end

    // generator state is never zero; a zero would lock it there
    a_lcg_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        lcg_reg != '0)
        else $error("generator state reached zero");

    // at most cap+1 points kept per cloud
    a_kept_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, kept_reg} <= {1'b0, cap_reg} + 22'd1)
        else $error("kept count above cap + 1");

    // a cloud start leaves at most one kept point
    a_first_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_first_reg |=> kept_reg <= 21'd1)
        else $error("kept count not cleared at cloud start");

    // a kept point gets a slot no higher than the cap in force
    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && keep_next |-> kept_cur <= cap_cur)
        else $error("kept slot beyond cap");

endmodule

`default_nettype wire
